### rtl/odf_pkg.sv
package odf_pkg;

  localparam int DW = 48;
  localparam int FB = 32;
  localparam int UW = DW - 1;
  localparam int PW = 2 * DW;

  localparam int EXP_TERMS = 12;
  localparam int EXP_QW = 17;
  localparam int EXP_AW = 34;
  localparam int RECIP_SH = 38;
  localparam int RECIP_W = 39;

  localparam logic [FB-1:0] LN2_FB = 32'hB17217F7;

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONE = DW'(1) << FB;

  localparam logic [1:0] REG_EDGE_RADIUS = 2'd0;
  localparam logic [1:0] REG_EDGE_WIDTH = 2'd1;
  localparam logic [1:0] REG_DEPL_START = 2'd2;
  localparam logic [1:0] REG_DEPL_SPAN = 2'd3;

  localparam logic [UW-1:0] EDGE_RADIUS_RST = 47'd4294967296;
  localparam logic [UW-1:0] EDGE_WIDTH_RST = 47'd429496730;
  localparam logic [UW-1:0] DEPL_START_RST = {UW{1'b1}};
  localparam logic [UW-1:0] DEPL_SPAN_RST = 47'd4294967296;

  typedef struct packed {
    logic signed [DW-1:0] rel_x;
    logic signed [DW-1:0] rel_y;
    logic signed [DW-1:0] rel_z;
    logic signed [DW-1:0] rel_vx;
    logic signed [DW-1:0] rel_vy;
    logic signed [DW-1:0] rel_vz;
    logic signed [DW-1:0] tau_semimajor;
    logic signed [DW-1:0] tau_eccentricity;
    logic signed [DW-1:0] tau_inclination;
    logic [2:0]           tau_set_mask;
    logic [UW-1:0]        sim_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] acc_x;
    logic signed [DW-1:0] acc_y;
    logic signed [DW-1:0] acc_z;
  } out_item_t;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // saturate a magnitude to the signed range and apply the sign
  function automatic logic [DW-1:0] pack_sat(input logic neg, input logic [63:0] q);
    logic [63:0] lim;
    logic [DW-1:0] m;
    lim = neg ? 64'(SMIN) : 64'(SMAX);
    m = (q > lim) ? lim[DW-1:0] : q[DW-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

  function automatic logic [DW-1:0] sadd(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return s[DW-1:0];
  endfunction

  // ceil(2^38 / term), exact floor division for operands below 2^34
  function automatic logic [RECIP_W-1:0] exp_recip(input logic [3:0] term);
    case (term)
      4'd1: return 39'd274877906944;
      4'd2: return 39'd137438953472;
      4'd3: return 39'd91625968982;
      4'd4: return 39'd68719476736;
      4'd5: return 39'd54975581389;
      4'd6: return 39'd45812984491;
      4'd7: return 39'd39268272421;
      4'd8: return 39'd34359738368;
      4'd9: return 39'd30541989661;
      4'd10: return 39'd27487790695;
      4'd11: return 39'd24988900632;
      4'd12: return 39'd22906492246;
      default: return '0;
    endcase
  endfunction

endpackage

### rtl/odf_stream_if.sv
interface odf_stream_if #(parameter type T = logic [0:0]) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/odf_delay.sv
module odf_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] line [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < N; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[N-1];
endmodule

### rtl/odf_mul.sv
module odf_mul #(
  parameter int AW = 48,
  parameter int BW = 48
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  localparam int H = AW / 2;

  logic [H+BW-1:0]      lo;
  logic [AW-H+BW-1:0]   hi;

  // two partial products, summed in the second stage
  always_ff @(posedge clk) begin
    if (en) begin
      lo <= a[H-1:0] * b;
      hi <= a[AW-1:H] * b;
      p  <= ((AW+BW)'(hi) << H) + (AW+BW)'(lo);
    end
  end
endmodule

### rtl/odf_div.sv
module odf_div #(
  parameter int NW = 96,
  parameter int DDW = 48,
  parameter int QW = 48
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  n,
  input  logic [DDW-1:0] d,
  output logic [QW-1:0]  q,
  output logic [DDW-1:0] r,
  output logic           ovf
);
  localparam int HW = NW - QW;
  localparam int CW = (HW > DDW) ? HW : DDW;

  logic [DDW-1:0] rem  [0:QW];
  logic [QW-1:0]  bits [0:QW];
  logic [DDW-1:0] dv   [0:QW];
  logic           of   [0:QW];
  logic [CW-1:0]  hi_x;
  logic [CW-1:0]  d_x;

  // quotient overflows QW bits when the top part is not below the divisor
  assign hi_x = CW'(n >> QW);
  assign d_x  = CW'(d);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DDW'(hi_x);
      bits[0] <= n[QW-1:0];
      dv[0]   <= d;
      of[0]   <= (hi_x >= d_x) && (n != '0);
    end
  end

  // a zero divisor with a zero dividend gives a zero quotient
  for (genvar k = 0; k < QW; k++) begin : g_step
    always_ff @(posedge clk) begin
      logic [DDW:0] tr;
      logic         ge;
      tr = {rem[k], bits[k][QW-1]};
      ge = (dv[k] != '0) && (tr >= {1'b0, dv[k]});
      if (en) begin
        rem[k+1]  <= ge ? DDW'(tr - {1'b0, dv[k]}) : tr[DDW-1:0];
        bits[k+1] <= {bits[k][QW-2:0], ge};
        dv[k+1]   <= dv[k];
        of[k+1]   <= of[k];
      end
    end
  end

  assign q   = of[QW] ? {QW{1'b1}} : bits[QW];
  assign r   = rem[QW];
  assign ovf = of[QW];
endmodule

### rtl/odf_sqrt.sv
module odf_sqrt #(
  parameter int NW = 96
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   n,
  output logic [NW/2-1:0] r
);
  localparam int STEPS = NW / 2;

  logic [NW-1:0] sn [0:STEPS];
  logic [NW-1:0] sr [0:STEPS];

  assign sn[0] = n;
  assign sr[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [NW-1:0] B = NW'(1) << (NW - 2 - 2 * k);
    always_ff @(posedge clk) begin
      logic [NW-1:0] tr;
      tr = sr[k] + B;
      if (en) begin
        if (sn[k] >= tr) begin
          sn[k+1] <= sn[k] - tr;
          sr[k+1] <= (sr[k] >> 1) + B;
        end else begin
          sn[k+1] <= sn[k];
          sr[k+1] <= sr[k] >> 1;
        end
      end
    end
  end

  assign r = sr[STEPS][NW/2-1:0];
endmodule

### rtl/odf_exp.sv
module odf_exp
  import odf_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] x,
  output logic [DW-1:0] e
);
  localparam int KW = EXP_QW + 2;
  localparam int NS = 2 * EXP_TERMS;
  localparam logic [EXP_AW-1:0] ONE_A = EXP_AW'(1) << FB;
  localparam int XH = DW - 15;
  localparam logic [17:0] LN2_RECIP = 18'd189096;
  localparam logic [FB+1:0] LN2_W = (FB+2)'(LN2_FB);

  logic [DW-1:0]        xa1, xa2;
  logic [XH+17:0]       kp;
  logic [EXP_QW-1:0]    k02, k03, kq_4;
  logic [EXP_QW+FB-1:0] kl;
  logic [FB+1:0]        r3;
  logic [FB-1:0]        rm_4;

  logic [EXP_QW-1:0] kq;
  logic [FB-1:0]     rm;
  logic              xn;

  logic [FB-1:0]     hf [0:NS];
  logic [KW-1:0]     hk [0:NS];
  logic [EXP_AW-1:0] hv [0:NS];

  // |x| / ln2 by a reciprocal estimate at most one low, then one correction
  assign kp = xa1[DW-1:15] * LN2_RECIP;
  assign kl = k02 * LN2_FB;

  always_ff @(posedge clk) begin
    if (en) begin
      xa1 <= mag(x);
      xa2 <= xa1;
      k02 <= kp[XH+17 -: EXP_QW];
      k03 <= k02;
      r3  <= (FB+2)'((EXP_QW+FB)'(xa2) - kl);
      if (r3 >= LN2_W) begin
        kq_4 <= k03 + 1'b1;
        rm_4 <= FB'(r3 - LN2_W);
      end else begin
        kq_4 <= k03;
        rm_4 <= r3[FB-1:0];
      end
    end
  end

  odf_delay #(.W(EXP_QW+FB), .N(EXP_QW - 3)) u_pad (
    .clk(clk), .en(en), .d({kq_4, rm_4}), .q({kq, rm})
  );

  odf_delay #(.W(1), .N(EXP_QW + 1)) u_sgn (.clk(clk), .en(en), .d(x[DW-1]), .q(xn));

  // floor split into k*ln2 + f with f non-negative
  always_ff @(posedge clk) begin
    if (en) begin
      if (xn) begin
        hk[0] <= KW'(0) - (KW'(kq) + KW'(rm != '0));
        hf[0] <= (rm != '0) ? (LN2_FB - rm) : '0;
      end else begin
        hk[0] <= KW'(kq);
        hf[0] <= rm;
      end
      hv[0] <= ONE_A;
    end
  end

  // horner steps: product stage, then division by the term index
  for (genvar s = 0; s < EXP_TERMS; s++) begin : g_term
    localparam logic [RECIP_W-1:0] M = exp_recip(4'(EXP_TERMS - s));
    logic [FB+EXP_AW-1:0]      pa;
    logic [EXP_AW+RECIP_W-1:0] pb;
    assign pa = hf[2*s] * hv[2*s];
    assign pb = hv[2*s+1] * M;
    always_ff @(posedge clk) begin
      if (en) begin
        hv[2*s+1] <= pa[FB+EXP_AW-1:FB];
        hf[2*s+1] <= hf[2*s];
        hk[2*s+1] <= hk[2*s];
        hv[2*s+2] <= ONE_A + EXP_AW'(pb[EXP_AW+RECIP_W-1:RECIP_SH]);
        hf[2*s+2] <= hf[2*s+1];
        hk[2*s+2] <= hk[2*s+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [DW-1:0] ax;
    logic [KW-1:0] nk;
    ax = DW'(hv[NS]);
    nk = KW'(0) - hk[NS];
    if (en) begin
      if (!hk[NS][KW-1]) begin
        if (hk[NS] >= KW'(DW - 1)) e <= SMAX;
        else if (ax > (SMAX >> hk[NS][5:0])) e <= SMAX;
        else e <= ax << hk[NS][5:0];
      end else begin
        if (nk >= KW'(64)) e <= '0;
        else e <= ax >> nk[5:0];
      end
    end
  end
endmodule

### rtl/orbit_damping_force_with_edge_top.sv
// throughput: one transaction per cycle; the pipeline advances whenever the
// output register is empty or being taken, otherwise every stage holds
// the pipeline depth is set by the chain sqrt, edge divider, exp, migration divider
// reset: clears the valid bits and loads the register defaults
module orbit_damping_force_with_edge_top
  import odf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [UW-1:0] cfg_data,
  odf_stream_if.sink    particle,
  odf_stream_if.source  accel
);
  localparam int LAT = 201;

  logic [UW-1:0] edge_radius, edge_width, depl_start, depl_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_radius <= EDGE_RADIUS_RST;
      edge_width  <= EDGE_WIDTH_RST;
      depl_start  <= DEPL_START_RST;
      depl_span   <= DEPL_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE_RADIUS: edge_radius <= cfg_data;
        REG_EDGE_WIDTH:  edge_width <= cfg_data;
        REG_DEPL_START:  depl_start <= cfg_data;
        REG_DEPL_SPAN:   depl_span <= cfg_data;
        default: ;
      endcase
    end
  end

  in_item_t      pin;
  out_item_t     pout;
  logic          en;
  logic [LAT:1]  vld;

  assign pin = particle.data;
  assign en = !vld[LAT] || accel.ready;
  assign particle.ready = en;
  assign accel.valid = vld[LAT];
  assign accel.data = pout;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-1:1], particle.valid};
  end

  // entry: magnitudes and signs
  logic [DW-1:0] pm [3];
  logic [DW-1:0] vmg [3];
  logic [2:0]    pn, vn;

  always_comb begin
    pm[0] = mag(pin.rel_x);  pn[0] = pin.rel_x[DW-1];
    pm[1] = mag(pin.rel_y);  pn[1] = pin.rel_y[DW-1];
    pm[2] = mag(pin.rel_z);  pn[2] = pin.rel_z[DW-1];
    vmg[0] = mag(pin.rel_vx); vn[0] = pin.rel_vx[DW-1];
    vmg[1] = mag(pin.rel_vy); vn[1] = pin.rel_vy[DW-1];
    vmg[2] = mag(pin.rel_vz); vn[2] = pin.rel_vz[DW-1];
  end

  logic [PW-1:0] sq [3];
  logic [PW-1:0] dp [3];
  logic [2:0]    dsg2;

  for (genvar j = 0; j < 3; j++) begin : g_sq
    odf_mul #(.AW(DW), .BW(DW)) u_sq (.clk(clk), .en(en), .a(pm[j]), .b(pm[j]), .p(sq[j]));
    odf_mul #(.AW(DW), .BW(DW)) u_dot (.clk(clk), .en(en), .a(pm[j]), .b(vmg[j]), .p(dp[j]));
  end

  odf_delay #(.W(3), .N(2)) u_dsg (.clk(clk), .en(en), .d(pn ^ vn), .q(dsg2));

  // sum of squares and signed dot product
  logic [PW-1:0] r2_3, pos_3, neg_3, vm_4;
  logic [63:0]   r2q_4;
  logic          vneg_4;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_3  <= sq[0] + sq[1] + sq[2];
      pos_3 <= (dsg2[0] ? '0 : dp[0]) + (dsg2[1] ? '0 : dp[1]) + (dsg2[2] ? '0 : dp[2]);
      neg_3 <= (dsg2[0] ? dp[0] : '0) + (dsg2[1] ? dp[1] : '0) + (dsg2[2] ? dp[2] : '0);
      vneg_4 <= neg_3 > pos_3;
      vm_4   <= (neg_3 > pos_3) ? (neg_3 - pos_3) : (pos_3 - neg_3);
      r2q_4  <= r2_3[PW-1:FB];
    end
  end

  // eccentricity: q = (v.r)/r2, then pre = 2q/tau_e
  logic [DW-1:0] qe1;
  logic          vneg_53;
  logic [DW:0]   te_53;
  logic [DW-1:0] q53;
  logic [DW-1:0] qe2;
  logic          n2_102;
  logic [DW-1:0] pre;
  logic [DW-1:0] pre_m;
  logic [3*DW-1:0] pm_102;
  logic [2:0]    pn_102;

  odf_div #(.NW(PW), .DDW(64), .QW(DW)) u_ecc_q (
    .clk(clk), .en(en), .n(vm_4), .d(r2q_4), .q(qe1), .r(), .ovf()
  );
  odf_delay #(.W(1), .N(49)) u_vneg (.clk(clk), .en(en), .d(vneg_4), .q(vneg_53));
  odf_delay #(.W(DW+1), .N(53)) u_te (
    .clk(clk), .en(en), .d({pin.tau_eccentricity[DW-1], mag(pin.tau_eccentricity)}), .q(te_53)
  );

  assign q53 = pack_sat(vneg_53, 64'(qe1));

  odf_div #(.NW(DW+FB+1), .DDW(DW), .QW(DW)) u_ecc_pre (
    .clk(clk), .en(en), .n({mag(q53), (FB+1)'(0)}), .d(te_53[DW-1:0]), .q(qe2), .r(), .ovf()
  );
  odf_delay #(.W(1), .N(49)) u_n2 (
    .clk(clk), .en(en), .d(q53[DW-1] ^ te_53[DW]), .q(n2_102)
  );
  odf_delay #(.W(3*DW+3), .N(102)) u_pos (
    .clk(clk), .en(en), .d({pm[2], pm[1], pm[0], pn}), .q({pm_102, pn_102})
  );

  assign pre = pack_sat(n2_102, 64'(qe2));
  assign pre_m = mag(pre);

  logic [2:0]    esg_104;
  logic [DW-1:0] ecc_105 [3];
  logic [DW-1:0] ecc_200 [3];

  odf_delay #(.W(3), .N(2)) u_esg (
    .clk(clk), .en(en), .d({3{pre[DW-1]}} ^ pn_102), .q(esg_104)
  );

  for (genvar j = 0; j < 3; j++) begin : g_ecc
    logic [PW-1:0] ep;
    odf_mul #(.AW(DW), .BW(DW)) u_mul (
      .clk(clk), .en(en), .a(pre_m), .b(pm_102[j*DW +: DW]), .p(ep)
    );
    always_ff @(posedge clk) begin
      if (en) ecc_105[j] <= pack_sat(esg_104[j], ep[PW-1:FB]);
    end
    odf_delay #(.W(DW), .N(95)) u_d (.clk(clk), .en(en), .d(ecc_105[j]), .q(ecc_200[j]));
  end

  // inclination: 2*vz/tau_i
  logic [DW-1:0] qi_49;
  logic          isg_49;
  logic [DW-1:0] inc_200;

  odf_div #(.NW(DW+FB+1), .DDW(DW), .QW(DW)) u_inc (
    .clk(clk), .en(en), .n({vmg[2], (FB+1)'(0)}), .d(mag(pin.tau_inclination)),
    .q(qi_49), .r(), .ovf()
  );
  odf_delay #(.W(1), .N(49)) u_isg (
    .clk(clk), .en(en), .d(vn[2] ^ pin.tau_inclination[DW-1]), .q(isg_49)
  );
  odf_delay #(.W(DW), .N(151)) u_incd (
    .clk(clk), .en(en), .d(pack_sat(isg_49, 64'(qi_49))), .q(inc_200)
  );

  // depletion fade factor
  logic [UW-1:0] dt;
  logic          late_33, dovf_33;
  logic [FB-1:0] dq_33;
  logic [FB:0]   fac_33;
  logic          late_144, dovf_144;
  logic [FB:0]   fac_144;

  assign dt = pin.sim_time - depl_start;

  odf_div #(.NW(UW+FB), .DDW(UW), .QW(FB)) u_depl (
    .clk(clk), .en(en), .n({dt, FB'(0)}), .d(depl_span), .q(dq_33), .r(), .ovf(dovf_33)
  );
  odf_delay #(.W(1), .N(33)) u_late (
    .clk(clk), .en(en), .d(pin.sim_time > depl_start), .q(late_33)
  );

  assign fac_33 = ((FB+1)'(1) << FB) - (FB+1)'(dq_33);

  odf_delay #(.W(FB+3), .N(111)) u_fac (
    .clk(clk), .en(en), .d({late_33, dovf_33, fac_33}), .q({late_144, dovf_144, fac_144})
  );

  // edge taper: sigma = 1 - exp(-(r - edge)/width)
  logic [DW-1:0] r_51;
  logic          inside_51, out_100;
  logic [DW-1:0] diff_51;
  logic [DW-1:0] qx_100;
  logic [DW-1:0] e_144;
  logic [DW-1:0] sig0_144, sig0_146;
  logic          late_146, dovf_146;
  logic [DW+FB:0] fp_146;
  logic [DW-1:0] sigma_f;

  odf_sqrt #(.NW(PW)) u_sqrt (.clk(clk), .en(en), .n(r2_3), .r(r_51));

  assign inside_51 = DW'(edge_radius) >= r_51;
  assign diff_51 = inside_51 ? (DW'(edge_radius) - r_51) : (r_51 - DW'(edge_radius));

  odf_div #(.NW(DW+FB), .DDW(UW), .QW(DW)) u_edge (
    .clk(clk), .en(en), .n({diff_51, FB'(0)}), .d(edge_width), .q(qx_100), .r(), .ovf()
  );
  odf_delay #(.W(1), .N(49)) u_in (.clk(clk), .en(en), .d(!inside_51), .q(out_100));

  odf_exp u_exp (.clk(clk), .en(en), .x(pack_sat(out_100, 64'(qx_100))), .e(e_144));

  assign sig0_144 = ONE - e_144;

  odf_mul #(.AW(DW), .BW(FB+1)) u_fade (
    .clk(clk), .en(en), .a(mag(sig0_144)), .b(fac_144), .p(fp_146)
  );
  odf_delay #(.W(DW+2), .N(2)) u_sig (
    .clk(clk), .en(en), .d({late_144, dovf_144, sig0_144}), .q({late_146, dovf_146, sig0_146})
  );

  always_ff @(posedge clk) begin
    if (en) begin
      if (!late_146) sigma_f <= sig0_146;
      else if (dovf_146) sigma_f <= '0;
      else sigma_f <= pack_sat(sig0_146[DW-1], 64'(fp_146[DW+FB:FB]));
    end
  end

  // migration: sigma*v/(2*tau_a)
  logic [3*DW-1:0] vm_147;
  logic [2:0]      vn_147;
  logic [DW:0]     ta_147;
  logic [DW-1:0]   ta_149;
  logic [2:0]      msg_199;
  logic [DW-1:0]   mig_200 [3];

  odf_delay #(.W(3*DW+3+DW+1), .N(147)) u_vel (
    .clk(clk), .en(en),
    .d({vmg[2], vmg[1], vmg[0], vn, pin.tau_semimajor[DW-1], mag(pin.tau_semimajor)}),
    .q({vm_147, vn_147, ta_147})
  );
  odf_delay #(.W(DW), .N(2)) u_ta (.clk(clk), .en(en), .d(ta_147[DW-1:0]), .q(ta_149));
  odf_delay #(.W(3), .N(52)) u_msg (
    .clk(clk), .en(en), .d({3{sigma_f[DW-1] ^ ta_147[DW]}} ^ vn_147), .q(msg_199)
  );

  for (genvar j = 0; j < 3; j++) begin : g_mig
    logic [PW-1:0] mp;
    logic [DW:0]   mq;
    odf_mul #(.AW(DW), .BW(DW)) u_mul (
      .clk(clk), .en(en), .a(mag(sigma_f)), .b(vm_147[j*DW +: DW]), .p(mp)
    );
    odf_div #(.NW(PW), .DDW(DW), .QW(DW+1)) u_div (
      .clk(clk), .en(en), .n(mp), .d(ta_149), .q(mq), .r(), .ovf()
    );
    always_ff @(posedge clk) begin
      if (en) mig_200[j] <= pack_sat(msg_199[j], 64'(mq[DW:1]));
    end
  end

  // combine the enabled terms into the output register
  logic [2:0]    mask_200;
  logic [DW-1:0] sum_x, sum_y, sum_z;

  odf_delay #(.W(3), .N(200)) u_mask (
    .clk(clk), .en(en), .d(pin.tau_set_mask), .q(mask_200)
  );

  always_comb begin
    sum_x = sadd(mask_200[0] ? mig_200[0] : '0, mask_200[1] ? ecc_200[0] : '0);
    sum_y = sadd(mask_200[0] ? mig_200[1] : '0, mask_200[1] ? ecc_200[1] : '0);
    sum_z = sadd(sadd(mask_200[0] ? mig_200[2] : '0, mask_200[1] ? ecc_200[2] : '0),
                 mask_200[2] ? inc_200 : '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pout.acc_x <= sum_x;
      pout.acc_y <= sum_y;
      pout.acc_z <= sum_z;
    end
  end

  a_no_valid_after_reset: assert property (@(posedge clk) rst |=> !accel.valid)
    else $error("result valid right after reset");

  a_empty_mask_zero: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-1] && mask_200 == 3'b000 |=> pout.acc_x == '0 && pout.acc_y == '0
      && pout.acc_z == '0)
    else $error("no term selected but result nonzero");

  a_depleted_sigma: assert property (@(posedge clk) disable iff (rst)
    en && vld[146] && late_146 && dovf_146 |=> sigma_f == '0)
    else $error("taper not zero after full depletion");

  a_exp_nonneg: assert property (@(posedge clk) disable iff (rst)
    vld[144] |-> !e_144[DW-1])
    else $error("exponential went negative");
endmodule
